// ===== sv/assert_macros.svh =====
// assertion macros shared by the rtl of the escape decoder
// no dependencies; macros expand to nothing when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define UE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define UE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define UE_ASSERT(lbl, clk, rst, prop, msg)
`define UE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== sv/ue2u8_pkg.sv =====
// shared types and constants of the unicode escape to utf-8 decoder
// no dependencies
package ue2u8_pkg;

   localparam int unsigned MaxResults = 3;

   typedef enum logic [2:0] {
      MODE_PLAIN = 3'b001,
      MODE_SLASH = 3'b010,
      MODE_BODY  = 3'b100
   } ue2u8_mode_type;

   typedef struct packed {
      ue2u8_mode_type mode;
      logic [2:0]     digits;
      logic [15:0]    code;
      logic           stopped;
   } ue2u8_state_type;

   // bytes[0] goes out first; done marks text_done on the final byte
   typedef struct packed {
      logic [MaxResults-1:0][7:0] bytes;
      logic [1:0]                 count;
      logic                       done;
   } ue2u8_res_type;

   localparam ue2u8_state_type StateClear = '{
      mode: MODE_PLAIN, digits: 3'd0, code: 16'h0000, stopped: 1'b0};

endpackage

// ===== sv/ue2u8_step.sv =====
// next-state and result logic for one input byte of the escape decoder
// depends on ue2u8_pkg
module ue2u8_step
   import ue2u8_pkg::*;
(
   input  ue2u8_state_type state_cur,
   input  logic [7:0]      in_byte,
   input  logic            text_end,
   output ue2u8_state_type state_nxt,
   output ue2u8_res_type   res
);

   localparam logic [7:0] Backslash = 8'h5C;
   localparam logic [7:0] LetterU   = 8'h75;

   function automatic ue2u8_res_type encode(input logic [15:0] code, input logic done);
      ue2u8_res_type r;
      r = '0;
      r.done = done;
      if (code <= 16'h007F) begin
         r.bytes[0] = code[7:0];
         r.count    = 2'd1;
      end else if (code <= 16'h07FF) begin
         r.bytes[0] = 8'hC0 | {3'b000, code[10:6]};
         r.bytes[1] = 8'h80 | {2'b00, code[5:0]};
         r.count    = 2'd2;
      end else begin
         r.bytes[0] = 8'hE0 | {4'b0000, code[15:12]};
         r.bytes[1] = 8'h80 | {2'b00, code[11:6]};
         r.bytes[2] = 8'h80 | {2'b00, code[5:0]};
         r.count    = 2'd3;
      end
      return r;
   endfunction

   logic        hex_ok;
   logic [3:0]  hex_val;
   logic [15:0] code_upd;
   logic [2:0]  digits_upd;

   always_comb begin
      hex_ok  = 1'b1;
      hex_val = 4'h0;
      if (in_byte inside {[8'h30:8'h39]}) begin
         hex_val = in_byte[3:0];
      end else if (in_byte inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
         hex_val = in_byte[3:0] + 4'd9;
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign code_upd   = (hex_ok && !state_cur.stopped) ? {state_cur.code[11:0], hex_val}
                                                      : state_cur.code;
   assign digits_upd = state_cur.digits + 3'd1;

   always_comb begin
      state_nxt = state_cur;
      res       = '0;
      res.done  = text_end;
      case (state_cur.mode)
         MODE_SLASH: begin
            if (in_byte == LetterU) begin
               state_nxt = StateClear;
               state_nxt.mode = MODE_BODY;
               if (text_end) begin
                  res = encode(16'h0000, text_end);
               end
            end else begin
               res.bytes[0] = Backslash;
               if (in_byte == Backslash && !text_end) begin
                  res.count = 2'd1;
                  state_nxt.mode = MODE_SLASH;
               end else begin
                  res.bytes[1] = in_byte;
                  res.count = 2'd2;
                  state_nxt.mode = MODE_PLAIN;
               end
            end
         end
         MODE_BODY: begin
            state_nxt.code    = code_upd;
            state_nxt.stopped = state_cur.stopped | ~hex_ok;
            state_nxt.digits  = digits_upd;
            if (digits_upd >= 3'd4 || text_end) begin
               res = encode(code_upd, text_end);
               state_nxt = StateClear;
            end
         end
         default: begin
            if (in_byte == Backslash && !text_end) begin
               state_nxt.mode = MODE_SLASH;
            end else begin
               res.bytes[0] = in_byte;
               res.count = 2'd1;
               state_nxt.mode = MODE_PLAIN;
            end
         end
      endcase
      // end of text always leaves a clean state for the next text
      if (text_end) begin
         state_nxt = StateClear;
      end
   end

endmodule

// ===== sv/unicode_escape_to_utf8_top.sv =====
// top level of the unicode escape to utf-8 decoder: scan state and result buffer
// depends on ue2u8_pkg, ue2u8_step and assert_macros.svh
//
// Usage:
//   req channel carries the source text one byte per item, req_tlast on the
//   final byte of a text. rsp channel returns the decoded utf-8 bytes, with
//   rsp_tlast on the last byte caused by one input item and rsp_tuser on the
//   final output byte of the whole text.
//   A "\uXXXX" escape becomes 1 to 3 output bytes; other bytes pass through.
//   Result bytes are registered; the first is presented in the cycle after its item.
//   Throughput: one input item per cycle while each item gives at most one
//   byte and the receiver takes each byte; an item that gives two or three
//   bytes holds req_tready low while the single-byte output port drains the
//   three-entry result buffer.
//   Items that give no byte (a backslash, escape digits) do not hold req_tready low.
//   Reset clears the scan state and empties the result buffer.
//   When the receiver stalls, the buffered bytes hold and req_tready drops
//   until the buffer is down to its last byte being taken.
`include "assert_macros.svh"
module unicode_escape_to_utf8_top
   import ue2u8_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,   // text_end
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast,   // run_last
   output logic       rsp_tuser    // [0] text_done
);

   ue2u8_state_type            state_ff, state_in;
   ue2u8_res_type              res;
   logic [MaxResults-1:0][7:0] slot_ff, slot_in;
   logic [1:0]                 count_ff, count_in;
   logic                       done_ff, done_in;
   logic                       req_fire, rsp_fire;

   ue2u8_step u_step (
      .state_cur (state_ff),
      .in_byte   (req_tdata),
      .text_end  (req_tlast),
      .state_nxt (state_in),
      .res       (res)
   );

   assign req_tready = (count_ff == 2'd0) || (count_ff == 2'd1 && rsp_tready);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = slot_ff[0];
   assign rsp_tlast  = (count_ff == 2'd1);
   assign rsp_tuser  = (count_ff == 2'd1) && done_ff;

   always_comb begin
      slot_in  = slot_ff;
      count_in = count_ff;
      done_in  = done_ff;
      if (req_fire) begin
         slot_in  = res.bytes;
         count_in = res.count;
         done_in  = res.done;
      end else if (rsp_fire) begin
         // shift the buffer down by one byte
         slot_in[0] = slot_ff[1];
         slot_in[1] = slot_ff[2];
         count_in   = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StateClear;
         count_ff <= 2'd0;
      end else begin
         if (req_fire) begin
            state_ff <= state_in;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      done_ff <= done_in;
   end

   `UE_ASSERT(a_stall_blocks_req, clock, reset, (rsp_tvalid && !rsp_tready) |-> !req_tready, "req accepted while result buffer stalled")
   `UE_ASSERT(a_done_is_last, clock, reset, (rsp_tvalid && rsp_tuser) |-> rsp_tlast, "text_done without run_last")
   `UE_ASSERT_NEXT(a_end_clears, clock, reset, req_fire && req_tlast, state_ff == StateClear, "scan state not cleared after text end")
   `UE_ASSERT_NEXT(a_load_count, clock, reset, req_fire, count_ff == $past(res.count), "result buffer count differs from decoded count")

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench of unicode_escape_to_utf8_top: directed table, then random text
// depends on ue2u8_pkg and the rtl of unicode_escape_to_utf8_top
module testbench
   import ue2u8_pkg::*;
();

   localparam logic [7:0] CharBackslash = 8'h5C;
   localparam logic [7:0] CharU         = 8'h75;
   localparam int         Predicted     = -1;
   localparam int         IdlePct       = 29;
   localparam int         RandomItems   = 195;
   localparam int         HoldCycles    = 60;

   typedef struct packed {
      logic [7:0] data;
      logic       run_last;
      logic       text_done;
   } utf8_item_type;

   // n_typed is the number of typed result bytes, or Predicted
   typedef struct {
      logic [7:0]      data;
      logic            fin;
      int              n_typed;
      logic [2:0][7:0] typed;
   } text_row_type;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;
   logic       req_tlast;
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;
   logic       rsp_tuser;

   // decoder state of the predictor
   ue2u8_mode_type scan_mode;
   logic [2:0]     body_count;
   logic [15:0]    code_acc;
   logic           hex_halted;

   utf8_item_type utf8_step[$];
   utf8_item_type utf8_expect[$];
   utf8_item_type utf8_want;

   int  error_count  = 0;
   int  items_sent   = 0;
   int  bytes_seen   = 0;
   bit  sender_steady = 1'b0;

   // typed rows: typed[0] leaves first
   text_row_type dir_table [25] = '{
      '{8'h41, 1'b0, 1, 24'h000041},
      '{8'h00, 1'b0, 1, 24'h000000},
      '{8'hFF, 1'b1, 1, 24'h0000FF},
      '{8'h5C, 1'b0, Predicted, 24'h0},
      '{8'h5C, 1'b0, Predicted, 24'h0},
      '{8'h6E, 1'b0, Predicted, 24'h0},
      '{8'h5C, 1'b0, Predicted, 24'h0},
      '{8'h75, 1'b0, Predicted, 24'h0},
      '{8'h46, 1'b0, Predicted, 24'h0},
      '{8'h66, 1'b0, Predicted, 24'h0},
      '{8'h46, 1'b0, Predicted, 24'h0},
      '{8'h66, 1'b0, Predicted, 24'h0},
      '{8'h5C, 1'b0, Predicted, 24'h0},
      '{8'h75, 1'b0, Predicted, 24'h0},
      '{8'h30, 1'b0, Predicted, 24'h0},
      '{8'h37, 1'b0, Predicted, 24'h0},
      '{8'h46, 1'b0, Predicted, 24'h0},
      '{8'h46, 1'b0, Predicted, 24'h0},
      '{8'h5C, 1'b0, Predicted, 24'h0},
      '{8'h75, 1'b1, 1, 24'h000000},
      '{8'h5C, 1'b1, 1, 24'h00005C},
      '{8'h5C, 1'b0, Predicted, 24'h0},
      '{8'h75, 1'b0, Predicted, 24'h0},
      '{8'h2B, 1'b0, Predicted, 24'h0},
      '{8'h61, 1'b1, Predicted, 24'h0}
   };

   unicode_escape_to_utf8_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      if (error_count < 50) $display("mismatch: %s", msg);
      error_count++;
   endtask

   function automatic int hex_nibble(input logic [7:0] b);
      if (b >= "0" && b <= "9") return int'(b - "0");
      if (b >= "A" && b <= "F") return int'(b - "A") + 10;
      if (b >= "a" && b <= "f") return int'(b - "a") + 10;
      return -1;
   endfunction

   function automatic void clear_scan();
      scan_mode  = MODE_PLAIN;
      body_count = 3'd0;
      code_acc   = 16'h0000;
      hex_halted = 1'b0;
   endfunction

   function automatic void emit_byte(input logic [7:0] b);
      utf8_item_type new_item;
      new_item = '{data: b, run_last: 1'b0, text_done: 1'b0};
      utf8_step.insert(utf8_step.size(), new_item);
   endfunction

   function automatic void emit_code(input logic [15:0] c);
      if (c <= 16'h007F) begin
         emit_byte(c[7:0]);
      end else if (c <= 16'h07FF) begin
         emit_byte({3'b110, c[10:6]});
         emit_byte({2'b10, c[5:0]});
      end else begin
         emit_byte({4'b1110, c[15:12]});
         emit_byte({2'b10, c[11:6]});
         emit_byte({2'b10, c[5:0]});
      end
   endfunction

   // advances the decoder by one input byte, leaves its output bytes in utf8_step
   function automatic void decode_byte(input logic [7:0] b, input logic fin);
      int h;
      h = hex_nibble(b);
      utf8_step.delete();
      case (scan_mode)
         MODE_SLASH: begin
            if (b == CharU) begin
               scan_mode  = MODE_BODY;
               body_count = 3'd0;
               code_acc   = 16'h0000;
               hex_halted = 1'b0;
               if (fin) emit_code(16'h0000);
            end else begin
               emit_byte(CharBackslash);
               if (b == CharBackslash && !fin) begin
                  scan_mode = MODE_SLASH;
               end else begin
                  emit_byte(b);
                  scan_mode = MODE_PLAIN;
               end
            end
         end
         MODE_BODY: begin
            if (!hex_halted && h >= 0) code_acc = {code_acc[11:0], 4'(h)};
            else hex_halted = 1'b1;
            body_count = body_count + 3'd1;
            if (body_count >= 3'd4 || fin) begin
               emit_code(code_acc);
               clear_scan();
            end
         end
         default: begin
            if (b == CharBackslash && !fin) begin
               scan_mode = MODE_SLASH;
            end else begin
               emit_byte(b);
               scan_mode = MODE_PLAIN;
            end
         end
      endcase
      if (fin) clear_scan();
      if (utf8_step.size() > 0) begin
         utf8_step[utf8_step.size()-1].run_last  = 1'b1;
         utf8_step[utf8_step.size()-1].text_done = fin;
      end
   endfunction

   task automatic send_item(input text_row_type row);
      int            k;
      utf8_item_type exp_item;
      @(negedge clock);
      while (!sender_steady && $urandom_range(99) < IdlePct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= row.data;
      req_tlast  <= row.fin;
      do @(posedge clock); while (req_tready !== 1'b1);
      decode_byte(row.data, row.fin);
      if (row.n_typed == Predicted) begin
         foreach (utf8_step[k]) utf8_expect.insert(utf8_expect.size(), utf8_step[k]);
      end else begin
         for (k = 0; k < row.n_typed; k++) begin
            exp_item = '{data: row.typed[k], run_last: k == row.n_typed - 1,
                         text_done: (k == row.n_typed - 1) && row.fin};
            utf8_expect.insert(utf8_expect.size(), exp_item);
         end
      end
      items_sent++;
   endtask

   function automatic logic [7:0] hex_char();
      string digits;
      digits = "0123456789abcdefABCDEF";
      return digits[$urandom_range(21)];
   endfunction

   // receiver: random stalls, one long hold-off, and a stretch that never stalls
   initial begin
      int  hold_left;
      bit  hold_done;
      hold_left  = 0;
      hold_done  = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && items_sent >= 70) begin
            hold_done = 1'b1;
            hold_left = HoldCycles;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (bytes_seen >= 40 && bytes_seen < 90) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= IdlePct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         bytes_seen++;
         if (utf8_expect.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %h", rsp_tdata));
         end else begin
            utf8_want = utf8_expect.pop_front();
            if (rsp_tdata !== utf8_want.data || rsp_tlast !== utf8_want.run_last ||
                rsp_tuser !== utf8_want.text_done)
               report_mismatch($sformatf("got %h/%b/%b, want %h/%b/%b",
                  rsp_tdata, rsp_tlast, rsp_tuser,
                  utf8_want.data, utf8_want.run_last, utf8_want.text_done));
         end
      end
   end

   initial begin
      #2000000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      text_row_type row;
      logic [7:0] seq[$];
      int         i;
      int         pick;
      int         zeros;
      int         rand_sent;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      req_tlast  = 1'b0;
      clear_scan();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_table[i]) send_item(dir_table[i]);

      rand_sent = 0;
      while (rand_sent < RandomItems) begin
         seq.delete();
         pick = $urandom_range(99);
         if (pick < 55) begin
            // escape with random digits, now and then a random byte; leading zeros reach the shorter encodings
            zeros = $urandom_range(3);
            seq.insert(seq.size(), CharBackslash);
            seq.insert(seq.size(), CharU);
            for (i = 0; i < 4; i++) begin
               if (i < zeros) seq.insert(seq.size(), 8'h30);
               else if ($urandom_range(9) == 0) seq.insert(seq.size(), 8'($urandom_range(255)));
               else seq.insert(seq.size(), hex_char());
            end
         end else if (pick < 70) begin
            seq.insert(seq.size(), CharBackslash);
            seq.insert(seq.size(), 8'($urandom_range(255)));
         end else begin
            for (i = 0; i <= $urandom_range(3); i++)
               seq.insert(seq.size(), 8'($urandom_range(255)));
         end
         foreach (seq[i]) begin
            sender_steady = (rand_sent >= 90 && rand_sent < 150);
            row.data    = seq[i];
            row.fin     = ($urandom_range(11) == 0);
            row.n_typed = Predicted;
            row.typed   = '0;
            send_item(row);
            rand_sent++;
         end
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      while (utf8_expect.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== unicode_escape_to_utf8_top.f =====
+incdir+sv
sv/ue2u8_pkg.sv
sv/ue2u8_step.sv
sv/unicode_escape_to_utf8_top.sv
tb/testbench.sv
